@@ hw/rtl/itoa_pkg.sv @@
// Shared types, constants and the digit-to-ASCII mapping for the radix converter.
// Used by itoa_ctrl, itoa_dpath and integer_to_radix_ascii; no dependencies.
package itoa_pkg;

  // The division unit retires STEP_BITS bits per cycle. VALUE_WIDTH must be a multiple of it.
  localparam int VALUE_WIDTH = 32;
  localparam int STEP_BITS   = 8;
  localparam int DIV_CYCLES  = VALUE_WIDTH / STEP_BITS;
  localparam int STEP_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int DIGIT_CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DIGIT_IDX_W = $clog2(VALUE_WIDTH);

  localparam int BASE_W = 6;
  localparam int REM_W  = BASE_W;
  localparam int CHAR_W = 8;

  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [REM_W-1:0]  DEC_DIGITS = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

  typedef enum logic [1:0] {
    SEL_SIGN,
    SEL_DIGIT,
    SEL_BAD
  } out_sel_e;

  typedef struct packed {
    logic                   load;
    logic                   div_step;
    logic                   div_first;
    logic                   div_last;
    logic                   push;
    out_sel_e               sel;
    logic                   last;
    logic [DIGIT_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
    logic neg;
    logic quo_zero;
    logic out_ready;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] letter_base;
    letter_base = lower ? CHAR_LOWER_A : CHAR_UPPER_A;
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + CHAR_W'(d);
    end else begin
      return letter_base + CHAR_W'(d - DEC_DIGITS);
    end
  endfunction

endpackage

@@ hw/rtl/integer_to_radix_ascii.sv @@
// Top level of the integer to radix ASCII converter.
// Instantiates itoa_ctrl and itoa_dpath; depends on itoa_pkg.

// One transfer in gives the ASCII digits of value in the given base, most significant
// first, one character per output transfer, with last on the final one; a negative
// signed value is preceded by a minus sign, and a base outside 2 to 36 gives a single
// null character with bad_base set. The block works on one item at a time: after the
// input cycle, the division unit produces each digit in turn, retiring eight quotient
// bits per cycle, and then each character is pushed into the output register, held
// back while that register is full and stalled. The next item is taken while the
// final character still waits in the output register.
module integer_to_radix_ascii (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [31:0]                 value_i,
  input  logic [itoa_pkg::BASE_W-1:0] base_i,
  input  logic                        lower_case_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0] character_o,
  output logic                        last_o,
  output logic                        bad_base_o
);
  import itoa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  itoa_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .value_i      (value_i),
    .base_i       (base_i),
    .lower_case_i (lower_case_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .character_o  (character_o),
    .last_o       (last_o),
    .bad_base_o   (bad_base_o)
  );

endmodule

@@ hw/rtl/itoa_dpath.sv @@
// Datapath of the radix converter: operand registers, the multi-bit division step,
// the digit buffer and the output register. Depends on itoa_pkg.
module itoa_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           func_i,
  input  logic [31:0]                    value_i,
  input  logic [itoa_pkg::BASE_W-1:0]    base_i,
  input  logic                           lower_case_i,
  input  itoa_pkg::cmd_t                 cmd_i,
  output itoa_pkg::sts_t                 sts_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [itoa_pkg::CHAR_W-1:0]    character_o,
  output logic                           last_o,
  output logic                           bad_base_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] num_q, num_d, num_nx;
  logic [REM_W-1:0]       rem_q, rem_nx;
  logic [BASE_W-1:0]      base_q;
  logic                   lower_q;
  logic                   neg_q;
  logic [REM_W-1:0]       dig_q [VALUE_WIDTH];

  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [VALUE_WIDTH-1:0] in_mag;

  logic                   valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;
  logic                   bad_q;
  logic [CHAR_W-1:0]      char_sel;

  assign in_val = value_i[VALUE_WIDTH-1:0];
  assign in_neg = func_i & in_val[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

  always_comb begin
    logic [REM_W:0]       t;
    logic [REM_W-1:0]     r;
    logic [STEP_BITS-1:0] q;
    r = cmd_i.div_first ? '0 : rem_q;
    q = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, num_q[VALUE_WIDTH-1-i]};
      if (t >= {1'b0, base_q}) begin
        t = t - {1'b0, base_q};
        q[STEP_BITS-1-i] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
    rem_nx = r;
    if (VALUE_WIDTH > STEP_BITS) begin
      num_nx = {num_q[VALUE_WIDTH-STEP_BITS-1:0], q};
    end else begin
      num_nx = VALUE_WIDTH'(q);
    end
  end

  always_comb begin
    num_d = num_q;
    if (cmd_i.load) begin
      num_d = in_mag;
    end else if (cmd_i.div_step) begin
      num_d = num_nx;
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_SIGN:  char_sel = CHAR_MINUS;
      SEL_DIGIT: char_sel = digit_char(dig_q[cmd_i.idx], lower_q);
      SEL_BAD:   char_sel = CHAR_NONE;
      default:   char_sel = CHAR_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    if (cmd_i.load) begin
      base_q  <= base_i;
      lower_q <= lower_case_i;
      neg_q   <= in_neg;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nx;
    end
    if (cmd_i.div_step && cmd_i.div_last) begin
      dig_q[cmd_i.idx] <= rem_nx;
    end
    if (cmd_i.push) begin
      char_q <= char_sel;
      last_q <= cmd_i.last;
      bad_q  <= (cmd_i.sel == SEL_BAD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign sts_o.in_bad    = (base_i < BASE_MIN) || (base_i > BASE_MAX);
  assign sts_o.neg       = neg_q;
  assign sts_o.quo_zero  = (num_nx == '0);
  assign sts_o.out_ready = !valid_q || !out_stall_i;

  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign bad_base_o  = bad_q;

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> rem_q < base_q)
    else $error("Division remainder is not below the base.");

  a_bad_is_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && cmd_i.sel == SEL_BAD) |=> (character_o == CHAR_NONE && last_o))
    else $error("A bad base result must be a null final character.");

endmodule

@@ hw/rtl/itoa_ctrl.sv @@
// Controller of the radix converter: sequences load, repeated division, sign and
// digit output. Drives itoa_dpath through cmd_t and reads sts_t; depends on itoa_pkg.
module itoa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output itoa_pkg::cmd_t cmd_o,
  input  itoa_pkg::sts_t sts_i
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_EMIT,
    S_BAD
  } state_e;

  state_e                 state_q, state_d;
  logic [STEP_CNT_W-1:0]  step_q, step_d;
  logic [DIGIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIGIT_CNT_W-1:0] cnt_m1;
  logic                   step_last;
  logic                   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign cnt_m1     = cnt_q - 1'b1;
  assign step_last  = (step_q == STEP_CNT_W'(DIV_CYCLES - 1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_DIGIT;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          cnt_d      = '0;
          state_d    = sts_i.in_bad ? S_BAD : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (step_q == '0);
        cmd_o.div_last  = step_last;
        cmd_o.idx       = cnt_q[DIGIT_IDX_W-1:0];
        if (step_last) begin
          step_d = '0;
          cnt_d  = cnt_q + 1'b1;
          if (sts_i.quo_zero) begin
            state_d = sts_i.neg ? S_SIGN : S_EMIT;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SIGN: begin
        cmd_o.sel = SEL_SIGN;
        if (sts_i.out_ready) begin
          cmd_o.push = 1'b1;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.idx  = cnt_m1[DIGIT_IDX_W-1:0];
        cmd_o.last = (cnt_m1 == '0);
        if (sts_i.out_ready) begin
          cmd_o.push = 1'b1;
          cnt_d      = cnt_m1;
          if (cnt_m1 == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      S_BAD: begin
        cmd_o.sel  = SEL_BAD;
        cmd_o.last = 1'b1;
        if (sts_i.out_ready) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  a_push_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_ready)
    else $error("A result was pushed into a full output register.");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIGIT_CNT_W'(VALUE_WIDTH))
    else $error("Digit count exceeds the value width.");

  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_SIGN) |-> cnt_q != '0)
    else $error("Output phase entered with no digits stored.");

endmodule

@@ bench/integer_to_radix_ascii_tb.sv @@
// Testbench for integer_to_radix_ascii: directed and random conversions with random
// idling on both channels, every character checked against a local prediction.
// Depends on itoa_pkg and the integer_to_radix_ascii RTL.
module integer_to_radix_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;

  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 320;
  localparam int IDLE_PERCENT  = 12;
  localparam int QUIET_FROM    = 4000;
  localparam int QUIET_TO      = 7000;
  localparam int HOLD_START    = 1500;
  localparam int HOLD_CYCLES   = 500;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic                func;
    logic [31:0]         value;
    logic [BASE_W-1:0]   base;
    logic                lower_case;
  } conv_item_t;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_base;
  } ascii_char_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              func_i = FUNC_UNSIGNED;
  logic [31:0]       value_i = '0;
  logic [BASE_W-1:0] base_i = '0;
  logic              lower_case_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CHAR_W-1:0] character_o;
  logic              last_o;
  logic              bad_base_o;

  conv_item_t  conv_pending_q[$];
  ascii_char_t ascii_expected_q[$];
  conv_item_t  offered_item;
  logic        all_sent = 1'b0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  int          err_cnt = 0;

  integer_to_radix_ascii DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .base_i      (base_i),
    .lower_case_i(lower_case_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .bad_base_o  (bad_base_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic idle_now();
    if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  function automatic void predict_conversion(input conv_item_t it);
    logic [31:0]       mag;
    logic              neg;
    logic [REM_W-1:0]  rem;
    logic [CHAR_W-1:0] digits[$];
    ascii_char_t       res;
    res.bad_base = 1'b0;
    res.last     = 1'b0;
    if (it.base < BASE_MIN || it.base > BASE_MAX) begin
      res.character = CHAR_NONE;
      res.last      = 1'b1;
      res.bad_base  = 1'b1;
      ascii_expected_q.push_back(res);
      return;
    end
    neg = (it.func == FUNC_SIGNED) && it.value[31];
    mag = neg ? -it.value : it.value;
    if (mag == '0) begin
      res.character = CHAR_ZERO;
      res.last      = 1'b1;
      ascii_expected_q.push_back(res);
      return;
    end
    while (mag != '0) begin
      rem = REM_W'(mag % 32'(it.base));
      if (rem < 10) begin
        digits.push_front(CHAR_ZERO + CHAR_W'(rem));
      end else begin
        digits.push_front((it.lower_case ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(rem - 10));
      end
      mag = mag / 32'(it.base);
    end
    if (neg) begin
      res.character = CHAR_MINUS;
      ascii_expected_q.push_back(res);
    end
    foreach (digits[i]) begin
      res.character = digits[i];
      res.last      = (i == digits.size() - 1);
      ascii_expected_q.push_back(res);
    end
  endfunction

  task automatic queue_item(input logic func, input logic [31:0] value,
                            input logic [BASE_W-1:0] base, input logic lower_case);
    conv_item_t it;
    it.func       = func;
    it.value      = value;
    it.base       = base;
    it.lower_case = lower_case;
    conv_pending_q.push_back(it);
  endtask

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0d ns: %s", $time, msg);
    end
  endtask

  // The sender only moves on when nothing is offered or the offered transfer completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_conversion(offered_item);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (conv_pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
          all_sent   <= 1'b1;
        end else if (idle_now()) begin
          in_valid_i <= 1'b0;
        end else begin
          offered_item = conv_pending_q.pop_front();
          in_valid_i   <= 1'b1;
          func_i       <= offered_item.func;
          value_i      <= offered_item.value;
          base_i       <= offered_item.base;
          lower_case_i <= offered_item.lower_case;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt == HOLD_START) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= (hold_left > 1) || idle_now();
    end
  end

  always @(posedge clk_i) begin
    ascii_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ascii_expected_q.size() == 0) begin
        note_error($sformatf("unexpected result: char %h last %b bad_base %b",
                             character_o, last_o, bad_base_o));
      end else begin
        want = ascii_expected_q.pop_front();
        if (character_o !== want.character || last_o !== want.last ||
            bad_base_o !== want.bad_base) begin
          note_error($sformatf({"mismatch: expected char %h last %b bad_base %b, ",
                                "got char %h last %b bad_base %b"},
                               want.character, want.last, want.bad_base,
                               character_o, last_o, bad_base_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          pick;
    logic [31:0] v;
    logic [BASE_W-1:0] b;

    queue_item(FUNC_UNSIGNED, 32'd123,        6'd0,  1'b0);
    queue_item(FUNC_SIGNED,   -32'sd5,        6'd1,  1'b1);
    queue_item(FUNC_UNSIGNED, 32'd0,          6'd37, 1'b0);
    queue_item(FUNC_SIGNED,   32'hFFFF_FFFF,  6'd63, 1'b1);
    queue_item(FUNC_UNSIGNED, 32'd0,          6'd10, 1'b0);
    queue_item(FUNC_SIGNED,   32'd0,          6'd2,  1'b1);
    queue_item(FUNC_UNSIGNED, 32'd0,          6'd36, 1'b0);
    queue_item(FUNC_SIGNED,   32'h8000_0000,  6'd10, 1'b0);
    queue_item(FUNC_SIGNED,   32'h8000_0000,  6'd2,  1'b0);
    queue_item(FUNC_SIGNED,   32'h8000_0000,  6'd16, 1'b1);
    queue_item(FUNC_UNSIGNED, 32'h8000_0000,  6'd10, 1'b0);
    queue_item(FUNC_UNSIGNED, 32'hFFFF_FFFF,  6'd2,  1'b0);
    queue_item(FUNC_SIGNED,   32'hFFFF_FFFF,  6'd2,  1'b0);
    queue_item(FUNC_UNSIGNED, 32'hFFFF_FFFF,  6'd36, 1'b1);
    queue_item(FUNC_UNSIGNED, 32'hFFFF_FFFF,  6'd36, 1'b0);
    queue_item(FUNC_UNSIGNED, 32'hFFFF_FFFF,  6'd16, 1'b0);
    queue_item(FUNC_SIGNED,   32'h7FFF_FFFF,  6'd10, 1'b0);
    queue_item(FUNC_SIGNED,   -32'sd1000,     6'd10, 1'b1);
    queue_item(FUNC_UNSIGNED, 32'd35,         6'd36, 1'b1);
    queue_item(FUNC_UNSIGNED, 32'd35,         6'd36, 1'b0);
    queue_item(FUNC_UNSIGNED, 32'd1,          6'd2,  1'b0);
    queue_item(FUNC_UNSIGNED, 32'd10,         6'd11, 1'b1);
    queue_item(FUNC_UNSIGNED, 32'd36,         6'd36, 1'b0);
    queue_item(FUNC_SIGNED,   32'hAAAA_AAAA,  6'd3,  1'b0);
    queue_item(FUNC_UNSIGNED, 32'h5555_5555,  6'd7,  1'b1);

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        b = $urandom_range(1) ? BASE_W'($urandom_range(1)) : BASE_W'($urandom_range(63, 37));
      end else if (pick < 18) begin
        b = 6'd2;
      end else if (pick < 28) begin
        b = 6'd36;
      end else begin
        b = BASE_W'($urandom_range(36, 2));
      end
      case ($urandom_range(3))
        0: v = $urandom >> $urandom_range(31);
        1: begin
          case ($urandom_range(5))
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = 32'h8000_0001;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default: v = $urandom;
      endcase
      queue_item($urandom_range(1) ? FUNC_SIGNED : FUNC_UNSIGNED, v, b, 1'($urandom_range(1)));
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!all_sent) @(posedge clk_i);
    while (ascii_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
